// ----- rtl/hidkb_pkg.sv -----
// Shared types and constants for the HID keyboard report builder.
package hidkb_pkg;

    // Number of key slots held in the pressed list
    localparam int KEY_SLOTS   = 6;
    // Width of each press counter
    localparam int COUNT_WIDTH = 8;
    // Slots carried in one report word
    localparam int OUT_SLOTS   = 6;
    // Modifier bits in the report
    localparam int MOD_BITS    = 8;
    // Keycode space
    localparam int KEY_CODES   = 256;
    // Width of the slot occupancy count
    localparam int FILL_W      = $clog2(KEY_SLOTS + 1);

    typedef enum logic [2:0] {
        REQ_KEY_PRESS = 3'd0,
        REQ_KEY_REL   = 3'd1,
        REQ_MOD_PRESS = 3'd2,
        REQ_MOD_REL   = 3'd3,
        REQ_ONE_SHOT  = 3'd4,
        REQ_SEND      = 3'd5
    } t_req_type;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] key_code;
        logic [7:0] modifier_mask;
    } t_in_word;

    typedef struct packed {
        logic [7:0] report_modifiers;
        logic [7:0] key_slot_0;
        logic [7:0] key_slot_1;
        logic [7:0] key_slot_2;
        logic [7:0] key_slot_3;
        logic [7:0] key_slot_4;
        logic [7:0] key_slot_5;
    } t_out_word;

endpackage

// ----- rtl/hid_keyboard_report_builder.sv -----
// Six-key HID boot keyboard report builder: press/release tracking and report emission.
//
// Takes one request word per cycle on the input channel. A request goes through
// two registers: the input register (which also reads the key's press counter
// from a 256-entry memory) and the result register, from which a report is
// driven onto the output. The rate of one word per
// cycle is held by the counter memory's single read and write port, with the
// counter just written forwarded to a back-to-back request for the same key.
// Counter entries carry a valid bit each, cleared at reset, so no clearing pass
// is needed. Only a send request that finds a change from the last report sent
// yields an output word; every other request yields nothing. Input stalls only
// when such a report is ready and the result register is still held.
module hid_keyboard_report_builder (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  hidkb_pkg::t_in_word  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output hidkb_pkg::t_out_word o_out_data
);
    import hidkb_pkg::*;

    // Counter memory and per-entry valid bits
    logic [COUNT_WIDTH-1:0] mem_cnt [KEY_CODES];
    logic [KEY_CODES-1:0]   r_key_vld;
    logic [COUNT_WIDTH-1:0] r_rd_cnt;
    logic                   r_byp;
    logic [COUNT_WIDTH-1:0] r_byp_cnt;

    // Input register
    logic     r_s1_valid;
    t_in_word r_in;

    // Keyboard state
    logic [7:0]             r_slots      [KEY_SLOTS];
    logic [7:0]             n_slots      [KEY_SLOTS];
    logic [7:0]             r_last_slots [KEY_SLOTS];
    logic [FILL_W-1:0]      r_fill;
    logic [FILL_W-1:0]      n_fill;
    logic [COUNT_WIDTH-1:0] r_mod_cnt [MOD_BITS];
    logic [COUNT_WIDTH-1:0] n_mod_cnt [MOD_BITS];
    logic [7:0]             r_one_shot;
    logic [7:0]             n_one_shot;
    logic [7:0]             r_last_mods;

    // Result register
    logic      r_out_valid;
    t_out_word r_out_data;

    // Stage decode and datapath
    logic                   in_acc;
    logic                   s1_adv;
    logic                   is_press;
    logic                   is_rel;
    logic                   is_mod;
    logic                   is_mod_press;
    logic                   is_one_shot;
    logic                   is_send;
    logic [COUNT_WIDTH-1:0] old_cnt;
    logic [COUNT_WIDTH-1:0] new_cnt;
    logic                   wr_en;
    logic [KEY_SLOTS-1:0]   match;
    logic [KEY_SLOTS-1:0]   at_or_after;
    logic                   found;
    logic                   code_nz;
    logic                   slots_full;
    logic                   do_add;
    logic                   do_rem;
    logic [7:0]             mods;
    logic                   slots_diff;
    logic                   emit;
    logic [7:0]             out_slots [OUT_SLOTS];
    logic                   tail_bad;
    logic                   dup_bad;

    // Decode the request held in the input register
    always_comb begin
        is_press     = 1'b0;
        is_rel       = 1'b0;
        is_mod       = 1'b0;
        is_mod_press = 1'b0;
        is_one_shot  = 1'b0;
        is_send      = 1'b0;
        case (r_in.req_type)
            REQ_KEY_PRESS: is_press = 1'b1;
            REQ_KEY_REL:   is_rel = 1'b1;
            REQ_MOD_PRESS: begin
                is_mod       = 1'b1;
                is_mod_press = 1'b1;
            end
            REQ_MOD_REL:   is_mod = 1'b1;
            REQ_ONE_SHOT:  is_one_shot = 1'b1;
            REQ_SEND:      is_send = 1'b1;
            default:       ;
        endcase
    end

    // Step the key counter, taking the just-written value when it is the same key
    always_comb begin
        if (r_byp) begin
            old_cnt = r_byp_cnt;
        end else if (r_key_vld[r_in.key_code]) begin
            old_cnt = r_rd_cnt;
        end else begin
            old_cnt = '0;
        end
        new_cnt = is_press ? old_cnt + COUNT_WIDTH'(1) : old_cnt - COUNT_WIDTH'(1);
    end

    // Locate the key in the list
    always_comb begin
        for (int i = 0; i < KEY_SLOTS; i++) begin
            match[i] = (r_slots[i] == r_in.key_code);
        end
        for (int i = 0; i < KEY_SLOTS; i++) begin
            at_or_after[i] = 1'b0;
            for (int j = 0; j <= i; j++) begin
                at_or_after[i] = at_or_after[i] | match[j];
            end
        end
        code_nz    = (r_in.key_code != 8'd0);
        found      = code_nz && (|match);
        slots_full = (r_fill == FILL_W'(KEY_SLOTS));
        do_add     = is_press && (new_cnt == COUNT_WIDTH'(1)) && code_nz && !found;
        do_rem     = is_rel && (new_cnt == '0) && found;
    end

    // Insert or remove a key, keeping the list packed
    always_comb begin
        n_slots = r_slots;
        n_fill  = r_fill;
        if (do_add) begin
            if (!slots_full) begin
                for (int i = 0; i < KEY_SLOTS; i++) begin
                    if (i == int'(r_fill)) begin
                        n_slots[i] = r_in.key_code;
                    end
                end
                n_fill = r_fill + FILL_W'(1);
            end else begin
                // drop the oldest key, append the new one
                for (int i = 0; i < KEY_SLOTS; i++) begin
                    if (i + 1 < KEY_SLOTS) begin
                        n_slots[i] = r_slots[i+1];
                    end else begin
                        n_slots[i] = r_in.key_code;
                    end
                end
            end
        end else if (do_rem) begin
            // close the gap from the removed slot upward
            for (int i = 0; i < KEY_SLOTS; i++) begin
                if (at_or_after[i]) begin
                    if (i + 1 < KEY_SLOTS) begin
                        n_slots[i] = r_slots[i+1];
                    end else begin
                        n_slots[i] = 8'd0;
                    end
                end
            end
            n_fill = r_fill - FILL_W'(1);
        end
    end

    // Modifier counters and one-shot mask
    always_comb begin
        for (int i = 0; i < MOD_BITS; i++) begin
            n_mod_cnt[i] = r_mod_cnt[i];
            if (is_mod && r_in.modifier_mask[i]) begin
                n_mod_cnt[i] = is_mod_press ? r_mod_cnt[i] + COUNT_WIDTH'(1)
                                            : r_mod_cnt[i] - COUNT_WIDTH'(1);
            end
        end
        if (is_one_shot) begin
            n_one_shot = r_one_shot | r_in.modifier_mask;
        end else if (is_send) begin
            n_one_shot = 8'd0;
        end else begin
            n_one_shot = r_one_shot;
        end
    end

    // Build the report and test it against the last one sent
    always_comb begin
        mods = r_one_shot;
        for (int i = 0; i < MOD_BITS; i++) begin
            if (r_mod_cnt[i] != '0) begin
                mods[i] = 1'b1;
            end
        end
        slots_diff = 1'b0;
        for (int i = 0; i < KEY_SLOTS; i++) begin
            if (r_slots[i] != r_last_slots[i]) begin
                slots_diff = 1'b1;
            end
        end
        emit = is_send && (slots_diff || (mods != r_last_mods));
        for (int i = 0; i < OUT_SLOTS; i++) begin
            if (i < KEY_SLOTS) begin
                out_slots[i] = r_slots[i];
            end else begin
                out_slots[i] = 8'd0;
            end
        end
    end

    // Handshake: advance unless a report is waiting on a full result register
    assign s1_adv     = r_s1_valid && (!emit || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_acc     = i_in_valid && o_in_ready;
    assign wr_en      = s1_adv && (is_press || is_rel);

    // Counter memory: read on accept, write back on advance
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd_cnt  <= mem_cnt[i_in_data.key_code];
            r_byp     <= wr_en && (r_in.key_code == i_in_data.key_code);
            r_byp_cnt <= new_cnt;
        end
        if (wr_en) begin
            mem_cnt[r_in.key_code] <= new_cnt;
        end
    end

    // Valid bits for the counter memory
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_vld <= '0;
        end else if (wr_en) begin
            r_key_vld[r_in.key_code] <= 1'b1;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_data;
        end
    end

    // Keyboard state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < KEY_SLOTS; i++) begin
                r_slots[i]      <= 8'd0;
                r_last_slots[i] <= 8'd0;
            end
            for (int i = 0; i < MOD_BITS; i++) begin
                r_mod_cnt[i] <= '0;
            end
            r_fill      <= '0;
            r_one_shot  <= 8'd0;
            r_last_mods <= 8'd0;
        end else if (s1_adv) begin
            r_slots    <= n_slots;
            r_fill     <= n_fill;
            r_mod_cnt  <= n_mod_cnt;
            r_one_shot <= n_one_shot;
            if (is_send) begin
                r_last_slots <= r_slots;
                r_last_mods  <= mods;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && emit) begin
            r_out_data.report_modifiers <= mods;
            r_out_data.key_slot_0       <= out_slots[0];
            r_out_data.key_slot_1       <= out_slots[1];
            r_out_data.key_slot_2       <= out_slots[2];
            r_out_data.key_slot_3       <= out_slots[3];
            r_out_data.key_slot_4       <= out_slots[4];
            r_out_data.key_slot_5       <= out_slots[5];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // List integrity checks
    always_comb begin
        tail_bad = 1'b0;
        dup_bad  = 1'b0;
        for (int i = 0; i < KEY_SLOTS; i++) begin
            if ((i >= int'(r_fill)) && (r_slots[i] != 8'd0)) begin
                tail_bad = 1'b1;
            end
            if ((i < int'(r_fill)) && (r_slots[i] == 8'd0)) begin
                tail_bad = 1'b1;
            end
            for (int j = 0; j < i; j++) begin
                if ((r_slots[i] != 8'd0) && (r_slots[i] == r_slots[j])) begin
                    dup_bad = 1'b1;
                end
            end
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(KEY_SLOTS))
        else $error("slot fill count exceeds slot count");

    a_list_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !tail_bad)
        else $error("pressed list is not packed");

    a_list_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !dup_bad)
        else $error("key listed twice");

    a_report_tracks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && emit) |=> (r_out_data.report_modifiers == r_last_mods))
        else $error("emitted modifiers differ from last sent");

endmodule

// ----- test/hid_keyboard_report_builder_tb.sv -----
// Testbench for the HID keyboard report builder: directed table, random requests, scoreboard.
`timescale 1ns / 1ps

module hid_keyboard_report_builder_tb;

    import hidkb_pkg::*;

    // Request codes with no meaning to the block
    localparam logic [2:0] REQ_SPARE_6 = 3'd6;
    localparam logic [2:0] REQ_SPARE_7 = 3'd7;

    localparam int RANDOM_ITEMS = 450;
    localparam int DRAIN_CYCLES = 64;
    localparam int KEY_POOL     = 12;

    // One row of the directed table
    typedef struct {
        t_in_word  word;
        bit        pinned;
        bit        pinned_has;
        t_out_word pinned_rep;
    } t_dir_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_word  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_word o_out_data;

    // Predictor state
    logic [COUNT_WIDTH-1:0] key_cnt [KEY_CODES];
    logic [COUNT_WIDTH-1:0] mod_cnt [MOD_BITS];
    logic [7:0]             one_shot;
    logic [7:0]             slot_list [KEY_SLOTS];
    int                     slot_fill;
    logic [7:0]             sent_slots [KEY_SLOTS];
    logic [7:0]             sent_mods;

    t_out_word pending_reports [$];
    t_dir_row  dir_rows [$];
    t_out_word head_rep;
    int        mismatch_count = 0;
    int        stall_left     = 0;
    bit        calm           = 1'b0;

    hid_keyboard_report_builder u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // Hard stop in case the block hangs
    initial begin
        #2000000;
        $display("hid_keyboard_report_builder test failed");
        $finish;
    end

    // Pick an idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Advance the keyboard state by one request; report the word a send emits
    task automatic apply_request(input t_in_word w, output bit emits, output t_out_word rep);
        logic [7:0] code;
        logic [7:0] mods;
        logic [7:0] outs [OUT_SLOTS];
        int         pos;
        bit         changed;
        begin
            emits = 1'b0;
            rep   = '0;
            code  = w.key_code;
            case (w.req_type)
                REQ_KEY_PRESS: begin
                    key_cnt[code] = key_cnt[code] + 1'b1;
                    if (key_cnt[code] == 1 && code != 8'd0) begin
                        pos = -1;
                        for (int i = 0; i < slot_fill; i++)
                            if (slot_list[i] == code)
                                pos = i;
                        if (pos < 0) begin
                            if (slot_fill < KEY_SLOTS) begin
                                slot_list[slot_fill] = code;
                                slot_fill++;
                            end else begin
                                // drop the oldest key, append the new one
                                for (int i = 0; i + 1 < KEY_SLOTS; i++)
                                    slot_list[i] = slot_list[i + 1];
                                slot_list[KEY_SLOTS - 1] = code;
                            end
                        end
                    end
                end
                REQ_KEY_REL: begin
                    key_cnt[code] = key_cnt[code] - 1'b1;
                    if (key_cnt[code] == 0 && code != 8'd0) begin
                        pos = -1;
                        for (int i = slot_fill - 1; i >= 0; i--)
                            if (slot_list[i] == code)
                                pos = i;
                        if (pos >= 0) begin
                            // close the gap
                            for (int i = pos; i + 1 < slot_fill; i++)
                                slot_list[i] = slot_list[i + 1];
                            slot_fill--;
                            slot_list[slot_fill] = 8'd0;
                        end
                    end
                end
                REQ_MOD_PRESS, REQ_MOD_REL: begin
                    for (int i = 0; i < MOD_BITS; i++)
                        if (w.modifier_mask[i])
                            mod_cnt[i] = (w.req_type == REQ_MOD_PRESS) ?
                                         mod_cnt[i] + 1'b1 : mod_cnt[i] - 1'b1;
                end
                REQ_ONE_SHOT: begin
                    one_shot = one_shot | w.modifier_mask;
                end
                REQ_SEND: begin
                    mods     = one_shot;
                    one_shot = 8'd0;
                    for (int i = 0; i < MOD_BITS; i++)
                        if (mod_cnt[i] != 0)
                            mods[i] = 1'b1;
                    changed = 1'b0;
                    for (int i = 0; i < KEY_SLOTS; i++) begin
                        if (sent_slots[i] != slot_list[i])
                            changed = 1'b1;
                        sent_slots[i] = slot_list[i];
                    end
                    if (mods != sent_mods) begin
                        sent_mods = mods;
                        changed   = 1'b1;
                    end
                    for (int i = 0; i < OUT_SLOTS; i++)
                        outs[i] = (i < KEY_SLOTS) ? slot_list[i] : 8'd0;
                    emits                = changed;
                    rep.report_modifiers = mods;
                    rep.key_slot_0       = outs[0];
                    rep.key_slot_1       = outs[1];
                    rep.key_slot_2       = outs[2];
                    rep.key_slot_3       = outs[3];
                    rep.key_slot_4       = outs[4];
                    rep.key_slot_5       = outs[5];
                end
                default: ;
            endcase
        end
    endtask

    // Hand one word to the block, then queue what it should emit
    task automatic push_word(input t_in_word w, input bit pinned, input bit pinned_has,
                             input t_out_word pinned_rep);
        int        gap;
        bit        emits;
        t_out_word rep;
        begin
            gap = pick_gap();
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_in_valid <= 1'b1;
            i_in_data  <= w;
            do @(posedge i_clk); while (!o_in_ready);
            apply_request(w, emits, rep);
            if (pinned) begin
                emits = pinned_has;
                rep   = pinned_rep;
            end
            if (emits)
                pending_reports.push_back(rep);
        end
    endtask

    task automatic add_row(input logic [2:0] req, input logic [7:0] code,
                           input logic [7:0] mask, input bit pinned, input bit has,
                           input t_out_word rep);
        t_dir_row row;
        begin
            row.word.req_type      = req;
            row.word.key_code      = code;
            row.word.modifier_mask = mask;
            row.pinned             = pinned;
            row.pinned_has         = has;
            row.pinned_rep         = rep;
            dir_rows.push_back(row);
        end
    endtask

    // Check each output word against the oldest queued report; pace out-side ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_reports.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected report: mods %h slots %h %h %h %h %h %h",
                             o_out_data.report_modifiers, o_out_data.key_slot_0,
                             o_out_data.key_slot_1, o_out_data.key_slot_2,
                             o_out_data.key_slot_3, o_out_data.key_slot_4,
                             o_out_data.key_slot_5);
            end else begin
                head_rep = pending_reports.pop_front();
                if (o_out_data.report_modifiers !== head_rep.report_modifiers ||
                    o_out_data.key_slot_0 !== head_rep.key_slot_0 ||
                    o_out_data.key_slot_1 !== head_rep.key_slot_1 ||
                    o_out_data.key_slot_2 !== head_rep.key_slot_2 ||
                    o_out_data.key_slot_3 !== head_rep.key_slot_3 ||
                    o_out_data.key_slot_4 !== head_rep.key_slot_4 ||
                    o_out_data.key_slot_5 !== head_rep.key_slot_5) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("report mismatch: exp %h | %h %h %h %h %h %h, got %h | %h %h %h %h %h %h",
                                 head_rep.report_modifiers, head_rep.key_slot_0,
                                 head_rep.key_slot_1, head_rep.key_slot_2,
                                 head_rep.key_slot_3, head_rep.key_slot_4,
                                 head_rep.key_slot_5,
                                 o_out_data.report_modifiers, o_out_data.key_slot_0,
                                 o_out_data.key_slot_1, o_out_data.key_slot_2,
                                 o_out_data.key_slot_3, o_out_data.key_slot_4,
                                 o_out_data.key_slot_5);
                end
            end
        end
        // hold ready low for a random stall, otherwise keep it high
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            stall_left = pick_gap();
            i_out_ready <= (stall_left == 0);
        end
    end

    initial begin
        t_in_word  w;
        t_out_word none_rep;
        t_out_word one_key_rep;
        int        r;
        int        done;

        // clear the predictor
        for (int i = 0; i < KEY_CODES; i++)
            key_cnt[i] = '0;
        for (int i = 0; i < MOD_BITS; i++)
            mod_cnt[i] = '0;
        for (int i = 0; i < KEY_SLOTS; i++) begin
            slot_list[i]  = 8'd0;
            sent_slots[i] = 8'd0;
        end
        one_shot  = 8'd0;
        sent_mods = 8'd0;
        slot_fill = 0;

        none_rep               = '0;
        one_key_rep            = '0;
        one_key_rep.key_slot_0 = 8'h04;

        // Directed table
        add_row(REQ_SEND,      8'hff, 8'hff, 1'b1, 1'b0, none_rep);    // nothing changed yet
        add_row(REQ_KEY_PRESS, 8'h04, 8'hff, 1'b0, 1'b0, none_rep);
        add_row(REQ_SEND,      8'h00, 8'h00, 1'b1, 1'b1, one_key_rep);
        add_row(REQ_SEND,      8'h00, 8'h00, 1'b1, 1'b0, none_rep);    // repeat: no change
        add_row(REQ_KEY_PRESS, 8'h00, 8'h00, 1'b0, 1'b0, none_rep);    // keycode zero
        add_row(REQ_KEY_PRESS, 8'h04, 8'h00, 1'b0, 1'b0, none_rep);    // already listed
        add_row(REQ_KEY_PRESS, 8'hff, 8'h00, 1'b0, 1'b0, none_rep);
        add_row(REQ_KEY_PRESS, 8'h05, 8'h00, 1'b0, 1'b0, none_rep);
        add_row(REQ_KEY_PRESS, 8'h06, 8'h00, 1'b0, 1'b0, none_rep);
        add_row(REQ_KEY_PRESS, 8'h07, 8'h00, 1'b0, 1'b0, none_rep);
        add_row(REQ_KEY_PRESS, 8'h08, 8'h00, 1'b0, 1'b0, none_rep);
        add_row(REQ_KEY_PRESS, 8'h09, 8'h00, 1'b0, 1'b0, none_rep);    // overflow drops oldest
        add_row(REQ_SEND,      8'h00, 8'h00, 1'b0, 1'b0, none_rep);
        add_row(REQ_KEY_REL,   8'h04, 8'h00, 1'b0, 1'b0, none_rep);
        add_row(REQ_KEY_REL,   8'h04, 8'h00, 1'b0, 1'b0, none_rep);    // dropped key reaches zero
        add_row(REQ_KEY_REL,   8'h05, 8'h00, 1'b0, 1'b0, none_rep);    // gap closes
        add_row(REQ_KEY_REL,   8'h10, 8'h00, 1'b0, 1'b0, none_rep);    // release wraps to max
        add_row(REQ_KEY_PRESS, 8'h10, 8'h00, 1'b0, 1'b0, none_rep);    // press wraps to zero
        add_row(REQ_KEY_REL,   8'h00, 8'h00, 1'b0, 1'b0, none_rep);
        add_row(REQ_MOD_PRESS, 8'h00, 8'hf0, 1'b0, 1'b0, none_rep);
        add_row(REQ_MOD_REL,   8'h00, 8'h03, 1'b0, 1'b0, none_rep);    // modifier wraps to max
        add_row(REQ_ONE_SHOT,  8'hff, 8'h08, 1'b0, 1'b0, none_rep);
        add_row(REQ_SEND,      8'hff, 8'hff, 1'b0, 1'b0, none_rep);
        add_row(REQ_SPARE_6,   8'hff, 8'hff, 1'b0, 1'b0, none_rep);
        add_row(REQ_SPARE_7,   8'hff, 8'hff, 1'b0, 1'b0, none_rep);
        add_row(REQ_SEND,      8'h00, 8'h00, 1'b0, 1'b0, none_rep);    // one-shot now cleared

        // hold reset, then release it on an edge
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k])
            push_word(dir_rows[k].word, dir_rows[k].pinned, dir_rows[k].pinned_has,
                      dir_rows[k].pinned_rep);

        // Random requests over a small key pool, with noise in unused fields
        done = 0;
        while (done < RANDOM_ITEMS) begin
            if (done % 60 == 0)
                calm = ($urandom_range(0, 3) == 0);
            w = t_in_word'($urandom);
            r = $urandom_range(0, 99);
            if (r < 3) begin
                w.req_type = ($urandom_range(0, 1) != 0) ? REQ_SPARE_6 : REQ_SPARE_7;
                push_word(w, 1'b0, 1'b0, none_rep);
                continue;
            end
            r = $urandom_range(0, 99);
            if (r < 28)
                w.req_type = REQ_KEY_PRESS;
            else if (r < 55)
                w.req_type = REQ_KEY_REL;
            else if (r < 64)
                w.req_type = REQ_MOD_PRESS;
            else if (r < 73)
                w.req_type = REQ_MOD_REL;
            else if (r < 80)
                w.req_type = REQ_ONE_SHOT;
            else
                w.req_type = REQ_SEND;
            if (w.req_type == REQ_KEY_PRESS || w.req_type == REQ_KEY_REL) begin
                r = $urandom_range(0, 99);
                if (r < 85)
                    w.key_code = 8'h04 + 8'($urandom_range(0, KEY_POOL - 1));
                else if (r < 90)
                    w.key_code = 8'h00;
            end
            if ((w.req_type == REQ_MOD_PRESS || w.req_type == REQ_MOD_REL) &&
                $urandom_range(0, 2) != 0)
                w.modifier_mask = 8'(1 << $urandom_range(0, MOD_BITS - 1));
            push_word(w, 1'b0, 1'b0, none_rep);
            done++;
        end
        i_in_valid <= 1'b0;

        // drain, then give the pipeline time to show any stray word
        while (pending_reports.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_reports.size() == 0)
            $display("hid_keyboard_report_builder test passed");
        else
            $display("hid_keyboard_report_builder test failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/hidkb_pkg.sv
rtl/hid_keyboard_report_builder.sv
test/hid_keyboard_report_builder_tb.sv
